>>> rtl/trade_ohlc_vwap_tracker_unit_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef TRADE_OHLC_VWAP_TRACKER_UNIT_DEFINES_SVH
`define TRADE_OHLC_VWAP_TRACKER_UNIT_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define TOV_ASSERT_SAME(label, cond, check, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (check)) \
		else $error(msg);

// Check that holds in the cycle after its trigger.
`define TOV_ASSERT_NEXT(label, cond, check, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (check)) \
		else $error(msg);

`endif

>>> rtl/tov_pkg.sv
// Shared widths, codes and types of the trade OHLC and VWAP tracker.
`default_nettype none

package tov_pkg;

	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS   = 32;
	localparam int VOL_BITS   = 64;
	localparam int TIME_BITS  = 64;
	localparam int COUNT_BITS = 32;

	// Volume is multiplied in two halves so each product fits one multiplier pass.
	localparam int HALF_BITS = VOL_BITS / 2;
	localparam int OPW_PQ    = (PRICE_BITS > QTY_BITS) ? PRICE_BITS : QTY_BITS;
	localparam int OPW_BITS  = (OPW_PQ > HALF_BITS) ? OPW_PQ : HALF_BITS;

	localparam int DIV_CNT_BITS = $clog2(VOL_BITS);

	localparam logic MODE_TRADE = 1'b0;
	localparam logic MODE_QUOTE = 1'b1;

	typedef struct packed {
		logic                start;
		logic [VOL_BITS-1:0] dividend;
		logic [VOL_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [PRICE_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/tov_event_if.sv
// Handshake channel that carries one market event per transaction.
`default_nettype none

interface tov_event_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [tov_pkg::TIME_BITS-1:0]  event_time;
	logic [tov_pkg::PRICE_BITS-1:0] trade_price;
	logic [tov_pkg::QTY_BITS-1:0]   trade_qty;
	logic [tov_pkg::PRICE_BITS-1:0] bid_price;
	logic [tov_pkg::PRICE_BITS-1:0] ask_price;

	modport source (
		output valid, mode, event_time, trade_price, trade_qty, bid_price, ask_price,
		input  ready
	);
	modport sink (
		input  valid, mode, event_time, trade_price, trade_qty, bid_price, ask_price,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/tov_result_if.sv
// Handshake channel that carries one statistics snapshot per transaction.
`default_nettype none

interface tov_result_if;
	logic                           valid;
	logic                           ready;
	logic [tov_pkg::PRICE_BITS-1:0] open_out;
	logic [tov_pkg::PRICE_BITS-1:0] high_out;
	logic [tov_pkg::PRICE_BITS-1:0] low_out;
	logic [tov_pkg::PRICE_BITS-1:0] last_out;
	logic [tov_pkg::PRICE_BITS-1:0] vwap_out;
	logic [tov_pkg::VOL_BITS-1:0]   volume_out;
	logic [tov_pkg::COUNT_BITS-1:0] count_out;
	logic [tov_pkg::PRICE_BITS-1:0] spread_out;
	logic [tov_pkg::TIME_BITS-1:0]  update_time_out;

	modport source (
		output valid, open_out, high_out, low_out, last_out, vwap_out, volume_out,
			count_out, spread_out, update_time_out,
		input  ready
	);
	modport sink (
		input  valid, open_out, high_out, low_out, last_out, vwap_out, volume_out,
			count_out, spread_out, update_time_out,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/tov_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module tov_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tov_pkg::div_req_t req,
	output tov_pkg::div_rsp_t      rsp
);

	localparam int VOL_W = tov_pkg::VOL_BITS;
	localparam int CNT_W = tov_pkg::DIV_CNT_BITS;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VOL_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VOL_W-1:0] rem_q;
	logic [VOL_W-1:0] quo_q;
	logic [VOL_W-1:0] dvs_q;
	logic [VOL_W:0]   trial;
	logic             take;

	// Shift the next dividend bit into the partial remainder and try the subtraction.
	assign trial = {rem_q, quo_q[VOL_W-1]} - {1'b0, dvs_q};
	assign take  = !trial[VOL_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift in behind the dividend bits as they are consumed.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[VOL_W-1:0] : {rem_q[VOL_W-2:0], quo_q[VOL_W-1]};
			quo_q <= {quo_q[VOL_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[tov_pkg::PRICE_BITS-1:0];

endmodule

`default_nettype wire

>>> rtl/trade_ohlc_vwap_tracker_unit.sv
// Running open, high, low, last, VWAP, volume, count and spread over a trade and quote feed.
//
// Every accepted event transaction produces exactly one result transaction, a snapshot of
// all statistics after that event. A quote goes from the accepting cycle straight to its
// result. A trade first runs through the multiply steps, in which a single 32-by-32
// multiplier forms vwap*volume (in two halves) and price*qty and accumulates them modulo
// 2^64. When its new volume is not zero, it then runs a radix-2 restoring divider that
// produces one quotient bit per cycle, and loads the new VWAP before its result is offered.
// The block takes one event at a time: the event channel is ready only while the block is
// idle, and the snapshot stays on the result channel until it is taken, so back-pressure
// on the result channel also holds off the next event.
`default_nettype none
`include "trade_ohlc_vwap_tracker_unit_defines.svh"

module trade_ohlc_vwap_tracker_unit (
	input wire logic     clk,
	input wire logic     arst_n,
	tov_event_if.sink    events,
	tov_result_if.source results
);

	localparam int PRICE_W = tov_pkg::PRICE_BITS;
	localparam int QTY_W   = tov_pkg::QTY_BITS;
	localparam int VOL_W   = tov_pkg::VOL_BITS;
	localparam int TIME_W  = tov_pkg::TIME_BITS;
	localparam int COUNT_W = tov_pkg::COUNT_BITS;
	localparam int HALF_W  = tov_pkg::HALF_BITS;
	localparam int OP_W    = tov_pkg::OPW_BITS;

	// Multiply steps: two volume halves against the old VWAP, then price by quantity.
	// The last step only folds the final product into the sum.
	localparam logic [1:0] MUL_VOL_LO = 2'd0;
	localparam logic [1:0] MUL_VOL_HI = 2'd1;
	localparam logic [1:0] MUL_TRADE  = 2'd2;
	localparam logic [1:0] MUL_LAST   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q;
	logic [1:0] mstep_q;

	// Architectural statistics; these are also the result payload.
	logic [PRICE_W-1:0] open_q;
	logic [PRICE_W-1:0] high_q;
	logic [PRICE_W-1:0] low_q;
	logic [PRICE_W-1:0] last_q;
	logic [PRICE_W-1:0] vwap_q;
	logic [VOL_W-1:0]   volume_q;
	logic [COUNT_W-1:0] count_q;
	logic [PRICE_W-1:0] spread_q;
	logic [TIME_W-1:0]  time_q;

	// Working registers of the current trade.
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	logic [VOL_W-1:0]   prod_q;
	logic               prod_shift_q;
	logic [VOL_W-1:0]   acc_q;

	logic               accept;
	logic               accept_trade;
	logic               mul_last;
	logic [OP_W-1:0]    mul_a;
	logic [OP_W-1:0]    mul_b;
	logic [2*OP_W-1:0]  mul_full;
	logic [VOL_W-1:0]   addend;
	logic [VOL_W-1:0]   acc_sum;
	logic [VOL_W-1:0]   vol_sum;

	tov_pkg::div_req_t div_req;
	tov_pkg::div_rsp_t div_rsp;

	assign accept       = events.valid && events.ready;
	assign accept_trade = accept && (events.mode == tov_pkg::MODE_TRADE);
	assign mul_last     = (state_q == S_MUL) && (mstep_q == MUL_LAST);

	// The one multiplier is fed a different operand pair in each multiply step.
	always_comb begin
		unique case (mstep_q)
			MUL_VOL_LO: begin
				mul_a = OP_W'(vwap_q);
				mul_b = OP_W'(volume_q[HALF_W-1:0]);
			end
			MUL_VOL_HI: begin
				mul_a = OP_W'(vwap_q);
				mul_b = OP_W'(volume_q[VOL_W-1:HALF_W]);
			end
			MUL_TRADE, MUL_LAST: begin
				mul_a = OP_W'(price_q);
				mul_b = OP_W'(qty_q);
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// The product of the upper volume half carries weight 2^32; bits shifted past bit 63
	// drop out, which is exactly the wrap of the 64-bit sum.
	assign addend  = prod_shift_q ? (prod_q << HALF_W) : prod_q;
	assign acc_sum = acc_q + addend;
	assign vol_sum = volume_q + VOL_W'(qty_q);

	assign div_req.start    = mul_last && (vol_sum != '0);
	assign div_req.dividend = acc_sum;
	assign div_req.divisor  = vol_sum;

	tov_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mstep_q  <= MUL_VOL_LO;
			open_q   <= '0;
			high_q   <= '0;
			low_q    <= '0;
			last_q   <= '0;
			vwap_q   <= '0;
			volume_q <= '0;
			count_q  <= '0;
			spread_q <= '0;
			time_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						time_q <= events.event_time;
						if (events.mode == tov_pkg::MODE_QUOTE) begin
							spread_q <= events.ask_price - events.bid_price;
							state_q  <= S_OUT;
						end else begin
							// A zero count, also after a wrap, restarts open, high and low.
							last_q <= events.trade_price;
							if (count_q == '0) begin
								open_q <= events.trade_price;
								high_q <= events.trade_price;
								low_q  <= events.trade_price;
							end else begin
								if (events.trade_price > high_q) begin
									high_q <= events.trade_price;
								end
								if (events.trade_price < low_q) begin
									low_q <= events.trade_price;
								end
							end
							count_q <= count_q + COUNT_W'(1);
							mstep_q <= MUL_VOL_LO;
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == MUL_LAST) begin
						// The volume is updated only after both old-volume products are formed.
						volume_q <= vol_sum;
						state_q  <= (vol_sum != '0) ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						vwap_q  <= div_rsp.quotient;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Trade operands and the multiply pipeline; none of these need a reset value.
	always_ff @(posedge clk) begin
		if (accept_trade) begin
			price_q <= events.trade_price;
			qty_q   <= events.trade_qty;
			acc_q   <= '0;
		end else if ((state_q == S_MUL) && (mstep_q != MUL_VOL_LO)) begin
			acc_q <= acc_sum;
		end
		if (state_q == S_MUL) begin
			prod_q       <= VOL_W'(mul_full);
			prod_shift_q <= (mstep_q == MUL_VOL_HI);
		end
	end

	assign events.ready = (state_q == S_IDLE);

	assign results.valid           = (state_q == S_OUT);
	assign results.open_out        = open_q;
	assign results.high_out        = high_q;
	assign results.low_out         = low_q;
	assign results.last_out        = last_q;
	assign results.vwap_out        = vwap_q;
	assign results.volume_out      = volume_q;
	assign results.count_out       = count_q;
	assign results.spread_out      = spread_q;
	assign results.update_time_out = time_q;

	// Once any trade has been counted, the high can never fall below the low.
	`TOV_ASSERT_SAME(a_high_not_below_low, count_q != '0, high_q >= low_q, "high below low")

	// A trade that leaves the volume at zero skips the divider and keeps the VWAP.
	`TOV_ASSERT_NEXT(a_zero_volume_keeps_vwap, mul_last && (vol_sum == '0),
		$stable(vwap_q) && (state_q == S_OUT), "zero volume changed vwap")

	// A quotient only arrives while the sequencer is waiting for it.
	`TOV_ASSERT_SAME(a_div_done_in_div, div_rsp.done, state_q == S_DIV,
		"divider finished outside division")

	// A snapshot that waits on the result channel is not disturbed.
	`TOV_ASSERT_NEXT(a_result_held, results.valid && !results.ready,
		$stable(volume_q) && $stable(vwap_q) && $stable(count_q), "snapshot changed")

endmodule

`default_nettype wire

>>> sim/trade_ohlc_vwap_tracker_unit_checker.sv
// Checker for the trade OHLC and VWAP tracker: follows both channels and compares snapshots.
`default_nettype none

module trade_ohlc_vwap_tracker_unit_checker (
	input wire logic clk,
	input wire logic arst_n,
	tov_event_if     feed,
	tov_result_if    snapshot,
	output int       failures,
	output int       pending
);
	import tov_pkg::*;

	typedef struct packed {
		logic [PRICE_BITS-1:0] open_px;
		logic [PRICE_BITS-1:0] high_px;
		logic [PRICE_BITS-1:0] low_px;
		logic [PRICE_BITS-1:0] last_px;
		logic [PRICE_BITS-1:0] vwap_px;
		logic [VOL_BITS-1:0]   volume;
		logic [COUNT_BITS-1:0] trades;
		logic [PRICE_BITS-1:0] spread;
		logic [TIME_BITS-1:0]  stamp;
	} market_stats_t;

	market_stats_t book = '0;
	market_stats_t expected_stats[$];
	int            mismatch_count = 0;

	assign failures = mismatch_count;

	// Folds one event into the running statistics. Products and the sum wrap at 64 bits.
	function automatic market_stats_t apply_event(
		input market_stats_t          s,
		input logic                   mode,
		input logic [TIME_BITS-1:0]   stamp,
		input logic [PRICE_BITS-1:0]  price,
		input logic [QTY_BITS-1:0]    qty,
		input logic [PRICE_BITS-1:0]  bid,
		input logic [PRICE_BITS-1:0]  ask
	);
		logic [VOL_BITS-1:0] carried;
		logic [VOL_BITS-1:0] added;
		logic [VOL_BITS-1:0] quotient;
		s.stamp = stamp;
		if (mode == MODE_TRADE) begin
			s.last_px = price;
			if (s.trades == '0) begin
				s.open_px = price;
				s.high_px = price;
				s.low_px  = price;
			end else begin
				if (price > s.high_px)
					s.high_px = price;
				if (price < s.low_px)
					s.low_px = price;
			end
			carried  = VOL_BITS'(s.vwap_px) * s.volume;
			added    = VOL_BITS'(price) * VOL_BITS'(qty);
			s.volume = s.volume + VOL_BITS'(qty);
			s.trades = s.trades + 1'b1;
			if (s.volume != '0) begin
				quotient  = (carried + added) / s.volume;
				s.vwap_px = quotient[PRICE_BITS-1:0];
			end
		end else begin
			s.spread = ask - bid;
		end
		return s;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Results are retired before new events are taken: no event can complete in its own cycle.
	always @(posedge clk or negedge arst_n) begin
		market_stats_t want;
		if (!arst_n) begin
			book = '0;
			expected_stats.delete();
			pending <= 0;
		end else begin
			if (snapshot.valid && snapshot.ready) begin
				if (expected_stats.size() == 0) begin
					$error("result transaction with no event outstanding");
					mismatch_count++;
				end else begin
					want = expected_stats.pop_front();
					check_field("open_out", want.open_px, snapshot.open_out);
					check_field("high_out", want.high_px, snapshot.high_out);
					check_field("low_out", want.low_px, snapshot.low_out);
					check_field("last_out", want.last_px, snapshot.last_out);
					check_field("vwap_out", want.vwap_px, snapshot.vwap_out);
					check_field("volume_out", want.volume, snapshot.volume_out);
					check_field("count_out", want.trades, snapshot.count_out);
					check_field("spread_out", want.spread, snapshot.spread_out);
					check_field("update_time_out", want.stamp, snapshot.update_time_out);
				end
			end
			if (feed.valid && feed.ready) begin
				book = apply_event(book, feed.mode, feed.event_time, feed.trade_price,
					feed.trade_qty, feed.bid_price, feed.ask_price);
				expected_stats.push_back(book);
			end
			pending <= expected_stats.size();
		end
	end

endmodule

`default_nettype wire

>>> sim/trade_ohlc_vwap_tracker_unit_tb.sv
// Testbench top for the trade OHLC and VWAP tracker: clock, reset, event stimulus and verdict.
`default_nettype none

module trade_ohlc_vwap_tracker_unit_tb;
	import tov_pkg::*;

	// Quiet time after the last phase, to cover any late result.
	localparam int SETTLE_CYCLES   = 100;
	// The timeout sits far above the slowest correct run; this leaves a wide margin.
	localparam int TIMEOUT_CYCLES  = 1500000;
	localparam int PHASE_ITEMS     = 500;
	localparam int PHASES          = 4;

	localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;
	localparam logic [QTY_BITS-1:0]   QTY_MAX   = '1;
	localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;

	typedef struct packed {
		logic                  mode;
		logic [TIME_BITS-1:0]  stamp;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
		logic [PRICE_BITS-1:0] bid;
		logic [PRICE_BITS-1:0] ask;
	} market_event_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   failures;
	int   pending;
	int   stamp_seq = 0;

	// Idle percentages for each random phase: none, sender only, receiver only, both.
	int   phase_send_pct[PHASES]  = '{0, 48, 0, 21};
	int   phase_stall_pct[PHASES] = '{0, 0, 48, 21};

	tov_event_if  feed();
	tov_result_if snapshot();

	trade_ohlc_vwap_tracker_unit u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (feed),
		.results (snapshot)
	);

	trade_ohlc_vwap_tracker_unit_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.snapshot (snapshot),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver decides afresh every cycle whether to stall. With a zero percentage
	// it takes a snapshot as soon as one is offered.
	always @(posedge clk) begin
		snapshot.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Trade events carry random bid and ask so that the block is seen to ignore them;
	// quotes likewise carry random trade fields.
	function automatic market_event_t make_trade(input logic [TIME_BITS-1:0] stamp,
			input logic [PRICE_BITS-1:0] price, input logic [QTY_BITS-1:0] qty);
		market_event_t ev;
		ev.mode  = MODE_TRADE;
		ev.stamp = stamp;
		ev.price = price;
		ev.qty   = qty;
		ev.bid   = $urandom;
		ev.ask   = $urandom;
		return ev;
	endfunction

	function automatic market_event_t make_quote(input logic [TIME_BITS-1:0] stamp,
			input logic [PRICE_BITS-1:0] bid, input logic [PRICE_BITS-1:0] ask);
		market_event_t ev;
		ev.mode  = MODE_QUOTE;
		ev.stamp = stamp;
		ev.price = $urandom;
		ev.qty   = $urandom;
		ev.bid   = bid;
		ev.ask   = ask;
		return ev;
	endfunction

	// Random events lean toward the edges: zero and full-scale prices and sizes, clustered
	// prices as a real book would show, crossed quotes and timestamps at both ends.
	function automatic market_event_t draw_event();
		logic [TIME_BITS-1:0]  stamp;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
		logic [PRICE_BITS-1:0] bid;
		logic [PRICE_BITS-1:0] ask;
		case ($urandom_range(19))
			0:       stamp = '0;
			1:       stamp = TIME_MAX;
			default: stamp = {$urandom, $urandom};
		endcase
		case ($urandom_range(9))
			0:       price = '0;
			1:       price = PRICE_MAX;
			2, 3:    price = $urandom_range(1100000, 900000);
			default: price = $urandom;
		endcase
		case ($urandom_range(9))
			0:       qty = '0;
			1:       qty = QTY_MAX;
			2, 3, 4: qty = $urandom_range(500, 1);
			default: qty = $urandom;
		endcase
		bid = $urandom;
		case ($urandom_range(3))
			0:       ask = bid + $urandom_range(64);
			1:       ask = bid - $urandom_range(64);
			2:       ask = bid;
			default: ask = $urandom;
		endcase
		if ($urandom_range(9) < 7)
			return make_trade(stamp, price, qty);
		return make_quote(stamp, bid, ask);
	endfunction

	// Offers one event and returns at the edge that accepts it. During a sender gap valid
	// is lowered once per idle cycle; a back-to-back event keeps valid high throughout.
	task automatic offer_event(input market_event_t ev);
		while ($urandom_range(99) < send_idle_pct) begin
			feed.valid <= 1'b0;
			@(posedge clk);
		end
		feed.valid       <= 1'b1;
		feed.mode        <= ev.mode;
		feed.event_time  <= ev.stamp;
		feed.trade_price <= ev.price;
		feed.trade_qty   <= ev.qty;
		feed.bid_price   <= ev.bid;
		feed.ask_price   <= ev.ask;
		do
			@(posedge clk);
		while (!feed.ready);
	endtask

	// Holds the sender off until every outstanding snapshot has been taken. The first
	// edge lets the checker count the event accepted at the previous edge.
	task automatic wait_for_quiet();
		feed.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		feed.valid       = 1'b0;
		feed.mode        = MODE_TRADE;
		feed.event_time  = '0;
		feed.trade_price = '0;
		feed.trade_qty   = '0;
		feed.bid_price   = '0;
		feed.ask_price   = '0;
		snapshot.ready   = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at full rate. The zero-volume trades must come first, while the
		// running volume is still zero; the first of them also opens the session.
		offer_event(make_quote(64'd1, 32'd5, 32'd3));
		offer_event(make_trade(64'd2, 32'd1000, '0));
		offer_event(make_trade('0, '0, '0));
		offer_event(make_trade(TIME_MAX, PRICE_MAX, 32'd1));
		offer_event(make_trade(64'd3, 32'd1000, 32'd1));
		// Full-scale size at full-scale price: the sum of the carried and new products wraps at 64 bits.
		offer_event(make_trade(64'd4, PRICE_MAX, QTY_MAX));
		offer_event(make_trade(64'd5, PRICE_MAX, QTY_MAX));
		offer_event(make_trade(64'd6, '0, QTY_MAX));
		offer_event(make_trade(64'd7, 32'd1, QTY_MAX));
		offer_event(make_trade(64'd8, 32'h8000_0000, 32'h8000_0000));
		offer_event(make_trade(64'd9, PRICE_MAX, QTY_MAX));
		offer_event(make_quote(TIME_MAX, PRICE_MAX, '0));
		offer_event(make_quote('0, '0, PRICE_MAX));
		offer_event(make_quote(64'd10, 32'h5555_5555, 32'h5555_5555));
		offer_event(make_quote(64'h8000_0000_0000_0000, 32'hAAAA_AAAA, 32'h5555_5555));
		offer_event(make_trade(64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
		offer_event(make_trade(64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
		offer_event(make_trade(64'd11, 32'd7, '0));
		wait_for_quiet();

		// Random part in phases of differing back-pressure. Each phase ends with the
		// sender held off until the block has delivered everything it owes.
		for (int phase = 0; phase < PHASES; phase++) begin
			send_idle_pct  = phase_send_pct[phase];
			recv_stall_pct = phase_stall_pct[phase];
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_event(draw_event());
			wait_for_quiet();
		end

		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("** trade_ohlc_vwap_tracker_unit: PASSED **");
		else
			$display("** trade_ohlc_vwap_tracker_unit: FAILED **");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("** trade_ohlc_vwap_tracker_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/tov_pkg.sv
rtl/tov_event_if.sv
rtl/tov_result_if.sv
rtl/tov_divider.sv
rtl/trade_ohlc_vwap_tracker_unit.sv
sim/trade_ohlc_vwap_tracker_unit_checker.sv
sim/trade_ohlc_vwap_tracker_unit_tb.sv
